// ===== sv/nptg_pkg.sv =====
// ----------------------------------------------------------------------------
// nptg_pkg: shared definitions for the nth prime table generator
// Defaults, field widths, seed primes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nptg_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int PRIME_WIDTH_DEF = 16;
    localparam int INDEX_W         = 13;
    localparam int PRIME_OUT_W     = 16;
    localparam int FIRST_PRIME     = 2;
    localparam int SECOND_PRIME    = 3;
    localparam int SEED_COUNT      = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_NEXT,
        ST_TRIAL,
        ST_LOAD,
        ST_SQUARE,
        ST_CMP,
        ST_DIV,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_n;
        logic rd_hit;
        logic next_cand;
        logic rd_trial;
        logic load_p;
        logic square;
        logic div_start;
        logic j_inc;
        logic append;
        logic mark_composite;
        logic res_invalid;
        logic res_hit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic n_invalid;
        logic hit;
        logic cand_ovf;
        logic j_end;
        logic sq_gt;
        logic div_done;
        logic rem_zero;
    } stat_t;

endpackage

// ===== sv/nptg_ram.sv =====
// ----------------------------------------------------------------------------
// nptg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are undefined until
// written.
// ----------------------------------------------------------------------------
module nptg_ram #(
    parameter int WIDTH = nptg_pkg::PRIME_WIDTH_DEF,
    parameter int DEPTH = nptg_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nptg_rem.sv =====
// ----------------------------------------------------------------------------
// nptg_rem: iterative remainder unit
// Restoring division that retires one dividend bit per cycle and keeps only
// the remainder.
// ----------------------------------------------------------------------------
module nptg_rem #(
    parameter int WIDTH = nptg_pkg::PRIME_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_sub;

    always_comb begin
        trial     = {rem_reg, dvd_reg[WIDTH-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dsr_reg}) ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/nptg_datapath.sv =====
// ----------------------------------------------------------------------------
// nptg_datapath: prime table, candidate registers and trial division
// Holds the table memory, the prime count, the last tested candidate, the
// trial prime and its square, the remainder unit and the result registers.
// ----------------------------------------------------------------------------
module nptg_datapath #(
    parameter int TABLE_DEPTH = nptg_pkg::TABLE_DEPTH_DEF,
    parameter int PRIME_WIDTH = nptg_pkg::PRIME_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nptg_pkg::cmd_t                  cmd,
    output nptg_pkg::stat_t                 stat,
    input  logic [nptg_pkg::INDEX_W-1:0]    s_index,
    output logic [nptg_pkg::PRIME_OUT_W-1:0] m_prime,
    output logic                            m_status
);

    localparam int W     = PRIME_WIDTH;
    localparam int OW    = nptg_pkg::PRIME_OUT_W;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CW > nptg_pkg::INDEX_W) ? CW : nptg_pkg::INDEX_W;

    logic [nptg_pkg::INDEX_W-1:0] n_reg;
    logic [CW-1:0]                count_reg;
    logic [W-1:0]                 last_reg;
    logic [W-1:0]                 cand_reg;
    logic [CW-1:0]                j_reg;
    logic [W-1:0]                 p_reg;
    logic [2*W-1:0]               sq_reg;
    logic                         lo_hit_reg;
    logic [W-1:0]                 lo_val_reg;
    logic [OW-1:0]                res_prime_reg;
    logic                         res_status_reg;
    logic [OW-1:0]                m_prime_reg;
    logic                         m_status_reg;

    logic [CMP_W-1:0]  n_ext;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  nm1;
    logic [W:0]        last_plus2;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [W-1:0]      ram_rdata;
    logic [W-1:0]      p_val;
    logic [W+OW-1:0]   p_wide;
    logic              div_done;
    logic [W-1:0]      rem;

    assign n_ext      = CMP_W'(n_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign nm1        = n_ext - CMP_W'(1);
    assign last_plus2 = {1'b0, last_reg} + (W+1)'(2);
    assign rd_addr    = cmd.rd_hit ? nm1[AW-1:0] : j_reg[AW-1:0];
    assign rd_en      = cmd.rd_hit | cmd.rd_trial;
    assign p_val      = lo_hit_reg ? lo_val_reg : ram_rdata;
    assign p_wide     = {{OW{1'b0}}, p_val};

    assign stat.n_invalid = (n_reg == '0) || (n_ext > CMP_W'(TABLE_DEPTH));
    assign stat.hit       = count_ext >= n_ext;
    assign stat.cand_ovf  = last_plus2[W];
    assign stat.j_end     = j_reg == count_reg;
    assign stat.sq_gt     = sq_reg > (2*W)'(cand_reg);
    assign stat.div_done  = div_done;
    assign stat.rem_zero  = rem == '0;

    nptg_ram #(
        .WIDTH(W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (cmd.append),
        .waddr(count_reg[AW-1:0]),
        .wdata(cand_reg),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    nptg_rem #(
        .WIDTH(W)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cand_reg),
        .divisor  (p_reg),
        .done     (div_done),
        .remainder(rem)
    );

    // The two seed primes are never stored in the memory; reads of their
    // slots are answered from constants.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(nptg_pkg::SEED_COUNT);
            last_reg  <= W'(nptg_pkg::SECOND_PRIME);
        end else begin
            if (cmd.append) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.append || cmd.mark_composite) begin
                last_reg <= cand_reg;
            end
        end
        if (cmd.load_n) begin
            n_reg <= s_index;
        end
        if (cmd.next_cand) begin
            cand_reg <= last_plus2[W-1:0];
            j_reg    <= '0;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + CW'(1);
        end
        if (rd_en) begin
            lo_hit_reg <= {1'b0, rd_addr} < (AW+1)'(nptg_pkg::SEED_COUNT);
            lo_val_reg <= rd_addr[0] ? W'(nptg_pkg::SECOND_PRIME) : W'(nptg_pkg::FIRST_PRIME);
        end
        if (cmd.load_p) begin
            p_reg <= p_val;
        end
        if (cmd.square) begin
            sq_reg <= p_reg * p_reg;
        end
        if (cmd.res_hit) begin
            res_prime_reg  <= p_wide[OW-1:0];
            res_status_reg <= 1'b0;
        end else if (cmd.res_invalid) begin
            res_prime_reg  <= '0;
            res_status_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_prime_reg  <= res_prime_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_prime  = m_prime_reg;
    assign m_status = m_status_reg;

endmodule

// ===== sv/nptg_ctrl.sv =====
// ----------------------------------------------------------------------------
// nptg_ctrl: sequencing controller
// Walks a request through validity check, table lookup, candidate stepping
// and trial division, and owns the handshake and the output valid register.
// ----------------------------------------------------------------------------
module nptg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  nptg_pkg::stat_t stat,
    output nptg_pkg::cmd_t  cmd
);

    nptg_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            nptg_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.load_n = s_valid;
                if (s_valid) begin
                    state_next = nptg_pkg::ST_CHECK;
                end
            end
            nptg_pkg::ST_CHECK: begin
                priority if (stat.n_invalid) begin
                    cmd.res_invalid = 1'b1;
                    state_next      = nptg_pkg::ST_DONE;
                end else if (stat.hit) begin
                    cmd.rd_hit = 1'b1;
                    state_next = nptg_pkg::ST_READ;
                end else begin
                    state_next = nptg_pkg::ST_NEXT;
                end
            end
            nptg_pkg::ST_READ: begin
                cmd.res_hit = 1'b1;
                state_next  = nptg_pkg::ST_DONE;
            end
            nptg_pkg::ST_NEXT: begin
                if (stat.cand_ovf) begin
                    cmd.res_invalid = 1'b1;
                    state_next      = nptg_pkg::ST_DONE;
                end else begin
                    cmd.next_cand = 1'b1;
                    state_next    = nptg_pkg::ST_TRIAL;
                end
            end
            nptg_pkg::ST_TRIAL: begin
                if (stat.j_end) begin
                    state_next = nptg_pkg::ST_APPEND;
                end else begin
                    cmd.rd_trial = 1'b1;
                    state_next   = nptg_pkg::ST_LOAD;
                end
            end
            nptg_pkg::ST_LOAD: begin
                cmd.load_p = 1'b1;
                state_next = nptg_pkg::ST_SQUARE;
            end
            nptg_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = nptg_pkg::ST_CMP;
            end
            nptg_pkg::ST_CMP: begin
                if (stat.sq_gt) begin
                    state_next = nptg_pkg::ST_APPEND;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = nptg_pkg::ST_DIV;
                end
            end
            nptg_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    if (stat.rem_zero) begin
                        cmd.mark_composite = 1'b1;
                        state_next         = nptg_pkg::ST_CHECK;
                    end else begin
                        cmd.j_inc  = 1'b1;
                        state_next = nptg_pkg::ST_TRIAL;
                    end
                end
            end
            nptg_pkg::ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = nptg_pkg::ST_CHECK;
            end
            nptg_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = nptg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nptg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nptg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/nth_prime_table_generator_unit.sv =====
// ----------------------------------------------------------------------------
// nth_prime_table_generator_unit: nth prime by trial division
// Returns the prime at a 1-based index, growing a table of primes on demand.
//
//   Channel | Direction | Ports                          | Item
//   s_      | in        | s_valid s_ready s_index        | 1-based prime index
//   m_      | out       | m_valid m_ready m_prime m_status | prime, invalid flag
//
// An invalid index and a cached index are answered without trial division.
// Each new candidate is divided by the stored primes in turn until one divides
// it, the square test ends the search or the table runs out; the bit-serial
// remainder unit sets the per-prime cost.
// Reset restores the two seed primes at once; no clearing pass is needed.
// A new item is accepted while a finished result still waits on m_ready.
// ----------------------------------------------------------------------------
module nth_prime_table_generator_unit #(
    parameter int TABLE_DEPTH = nptg_pkg::TABLE_DEPTH_DEF,
    parameter int PRIME_WIDTH = nptg_pkg::PRIME_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [nptg_pkg::INDEX_W-1:0]     s_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nptg_pkg::PRIME_OUT_W-1:0] m_prime,
    output logic                             m_status
);

    nptg_pkg::cmd_t  cmd;
    nptg_pkg::stat_t stat;

    nptg_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    nptg_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .PRIME_WIDTH(PRIME_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_index (s_index),
        .m_prime (m_prime),
        .m_status(m_status)
    );

endmodule

// ===== sv/nptg_checker.sv =====
// ----------------------------------------------------------------------------
// nptg_checker: port-level checks for the nth prime table generator
// Watches both channels for stable stalls, clean reset and the shape of
// valid and invalid answers.
// ----------------------------------------------------------------------------
module nptg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [nptg_pkg::INDEX_W-1:0]     s_index,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [nptg_pkg::PRIME_OUT_W-1:0] m_prime,
    input logic                             m_status
);

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_index))
        else $error("Input item changed while waiting.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime) && $stable(m_status))
        else $error("Result item changed while stalled.");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_prime == '0)
        else $error("Invalid item carries a nonzero prime.");

    a_prime_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_prime[0] || (m_prime == nptg_pkg::PRIME_OUT_W'(2)))
        else $error("Valid item is even and not two.");

endmodule

bind nth_prime_table_generator_unit nptg_checker u_nptg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_index (s_index),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_prime (m_prime),
    .m_status(m_status)
);
